FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds.
`define PRP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cond never holds.
`define PRP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

FILE: sv/prp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prp_pkg;

  localparam int unsigned DW         = 32;
  localparam int unsigned XY_W       = 36;
  localparam int unsigned Z_W        = 34;
  localparam int unsigned K_W        = 30;
  localparam int unsigned HALF_W     = XY_W / 2;
  localparam int unsigned PP_W       = HALF_W + K_W;
  localparam int unsigned SUM_W      = XY_W + K_W;
  localparam int unsigned MAX_STAGES = 32;
  localparam int unsigned STAGES_DEF = 24;

  localparam logic [K_W-1:0]   K_GAIN    = 30'h26DD3B6A;
  localparam logic [SUM_W-1:0] ROUND_BIT = {{(SUM_W-K_W){1'b0}}, 1'b1, {(K_W-1){1'b0}}};
  localparam logic [Z_W-1:0]   Z_HALF    = {{(Z_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

  localparam logic [XY_W-1:0] MAG_MAX_POS = {{(XY_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [XY_W-1:0] MAG_MAX_NEG = {{(XY_W-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]   SAT_POS     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]   SAT_NEG     = {1'b1, {(DW-1){1'b0}}};

  localparam logic [DW-1:0] ATAN_TAB [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    OP_ROTATE   = 2'd0,
    OP_TO_CART  = 2'd1,
    OP_TO_POLAR = 2'd2,
    OP_DIST     = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic                    zero;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } stage_t;

endpackage

`default_nettype wire

FILE: sv/planar_rotate_polar_unit.sv
// Planar vector unit on a pipelined CORDIC core: rotate, polar to cartesian,
// cartesian to polar and point distance, Q16.16 coordinates and 32-bit binary
// angles, gain removed, results saturated. One beat is taken every cycle:
// busy_o stays low, so start_i is accepted whenever it is high. Each result
// appears on rx_o, ry_o and clipped_o for one cycle with done_o high, after
// two setup stages, one register per CORDIC micro-rotation and four gain and
// saturation stages, in start order. There is no stall path: the receiver
// must take each result when done_o is high.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module planar_rotate_polar_unit #(
  parameter int unsigned STAGES = prp_pkg::STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             op_i,
  input  logic [prp_pkg::DW-1:0] ax_i,
  input  logic [prp_pkg::DW-1:0] ay_i,
  input  logic [prp_pkg::DW-1:0] bx_i,
  input  logic [prp_pkg::DW-1:0] by_i,
  input  logic [prp_pkg::DW-1:0] turn_i,
  output logic                   done_o,
  output logic [prp_pkg::DW-1:0] rx_o,
  output logic [prp_pkg::DW-1:0] ry_o,
  output logic                   clipped_o
);

  import prp_pkg::*;

  localparam int unsigned LAT = STAGES + 6;

  logic                   accept;
  op_e                    op_in;
  logic signed [XY_W-1:0] ax_ext, ay_ext, bx_ext, by_ext;

  // input stage
  logic                   s0_valid_q;
  op_e                    s0_op_q;
  logic signed [XY_W-1:0] s0_x_d, s0_y_d, s0_x_q, s0_y_q;
  logic [DW-1:0]          s0_ang_d, s0_ang_q;

  // setup stage
  logic                   s1_valid_q;
  logic                   s1_flip;
  stage_t                 s1_d, s1_q;

  logic                   valid_pipe [STAGES+1];
  stage_t                 stage_pipe [STAGES+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op_in  = op_e'(op_i);
  assign ax_ext = {{(XY_W-DW){ax_i[DW-1]}}, ax_i};
  assign ay_ext = {{(XY_W-DW){ay_i[DW-1]}}, ay_i};
  assign bx_ext = {{(XY_W-DW){bx_i[DW-1]}}, bx_i};
  assign by_ext = {{(XY_W-DW){by_i[DW-1]}}, by_i};

  always_comb begin
    s0_x_d   = ax_ext;
    s0_y_d   = ay_ext;
    s0_ang_d = turn_i;
    case (op_in)
      OP_ROTATE: begin
        s0_ang_d = turn_i;
      end
      OP_TO_CART: begin
        s0_y_d   = '0;
        s0_ang_d = ay_i;
      end
      OP_TO_POLAR: begin
        s0_ang_d = '0;
      end
      default: begin
        s0_x_d   = bx_ext - ax_ext;
        s0_y_d   = by_ext - ay_ext;
        s0_ang_d = '0;
      end
    endcase
  end

  // fold the half plane: rotation by angle quadrant, vectoring by sign of x
  assign s1_flip = (s0_ang_q[DW-1:DW-2] == 2'b01) || (s0_ang_q[DW-1:DW-2] == 2'b10);

  always_comb begin
    s1_d.op   = s0_op_q;
    s1_d.zero = (s0_x_q == '0) && (s0_y_q == '0);
    s1_d.x    = s0_x_q;
    s1_d.y    = s0_y_q;
    if (s0_op_q == OP_TO_POLAR || s0_op_q == OP_DIST) begin
      s1_d.z = '0;
      if (s0_x_q[XY_W-1]) begin
        s1_d.x = -s0_x_q;
        s1_d.y = -s0_y_q;
        s1_d.z = Z_HALF;
      end
    end else begin
      s1_d.z = {{(Z_W-DW){s0_ang_q[DW-1]}}, s0_ang_q};
      if (s1_flip) begin
        s1_d.x = -s0_x_q;
        s1_d.y = -s0_y_q;
        s1_d.z = {{(Z_W-DW+1){~s0_ang_q[DW-1]}}, s0_ang_q[DW-2:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_op_q  <= op_in;
    s0_x_q   <= s0_x_d;
    s0_y_q   <= s0_y_d;
    s0_ang_q <= s0_ang_d;
    s1_q     <= s1_d;
  end

  assign valid_pipe[0] = s1_valid_q;
  assign stage_pipe[0] = s1_q;

  for (genvar k = 0; k < STAGES; k++) begin : g_cordic
    prp_stage #(
      .IDX (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_pipe[k]),
      .stage_i (stage_pipe[k]),
      .valid_o (valid_pipe[k+1]),
      .stage_o (stage_pipe[k+1])
    );
  end

  prp_gain u_gain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_pipe[STAGES]),
    .stage_i   (stage_pipe[STAGES]),
    .done_o    (done_o),
    .rx_o      (rx_o),
    .ry_o      (ry_o),
    .clipped_o (clipped_o)
  );

  `PRP_ASSERT_IMPLY(a_done_latency, done_o, $past(accept, LAT))
  `PRP_ASSERT_IMPLY(a_dist_ry_zero, done_o && $past(accept && op_in == OP_DIST, LAT), ry_o == '0)
  `PRP_ASSERT_IMPLY(a_mag_nonneg, done_o && $past(accept && (op_in == OP_TO_POLAR || op_in == OP_DIST), LAT), !rx_o[DW-1])
  `PRP_ASSERT_NEVER(a_clip_strobe, clipped_o && !done_o)

endmodule

`default_nettype wire

FILE: sv/prp_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module prp_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  prp_pkg::stage_t stage_i,
  output logic            valid_o,
  output prp_pkg::stage_t stage_o
);

  import prp_pkg::*;

  logic signed [XY_W-1:0] x_in, y_in, xs, ys;
  logic signed [Z_W-1:0]  z_in, atan_z;
  logic                   down;
  logic                   valid_q;
  stage_t                 stage_d, stage_q;

  assign x_in   = stage_i.x;
  assign y_in   = stage_i.y;
  assign z_in   = stage_i.z;
  assign xs     = x_in >>> IDX;
  assign ys     = y_in >>> IDX;
  assign atan_z = {{(Z_W-DW){1'b0}}, ATAN_TAB[IDX]};

  // vectoring steers on y, rotation on the residual angle
  assign down = (stage_i.op == OP_TO_POLAR || stage_i.op == OP_DIST) ?
                y_in[XY_W-1] : !z_in[Z_W-1];

  always_comb begin
    stage_d      = stage_i;
    if (down) begin
      stage_d.x = x_in - ys;
      stage_d.y = y_in + xs;
      stage_d.z = z_in - atan_z;
    end else begin
      stage_d.x = x_in + ys;
      stage_d.y = y_in - xs;
      stage_d.z = z_in + atan_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: sv/prp_gain.sv
`timescale 1ns / 1ps
`default_nettype none

module prp_gain (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  prp_pkg::stage_t        stage_i,
  output logic                   done_o,
  output logic [prp_pkg::DW-1:0] rx_o,
  output logic [prp_pkg::DW-1:0] ry_o,
  output logic                   clipped_o
);

  import prp_pkg::*;

  logic                   vec;
  logic signed [XY_W-1:0] x_in, y_in;

  // magnitude stage
  logic              g0_valid_q, g0_vec_q, g0_negx_q, g0_negy_q;
  logic [XY_W-1:0]   g0_mx_d, g0_my_d, g0_mx_q, g0_my_q;
  logic [DW-1:0]     g0_ang_d, g0_ang_q;

  // partial product stage
  logic              g1_valid_q, g1_vec_q, g1_negx_q, g1_negy_q;
  logic [PP_W-1:0]   g1_xlo_q, g1_xhi_q, g1_ylo_q, g1_yhi_q;
  logic [DW-1:0]     g1_ang_q;

  // round stage
  logic              g2_valid_q, g2_vec_q, g2_negx_q, g2_negy_q;
  logic [SUM_W-1:0]  sum_x, sum_y;
  logic [XY_W-1:0]   g2_rx_q, g2_ry_q;
  logic [DW-1:0]     g2_ang_q;

  // saturate stage
  logic              clip_x, clip_y;
  logic [DW-1:0]     val_x, val_y;
  logic              done_q, clipped_d, clipped_q;
  logic [DW-1:0]     rx_d, ry_d, rx_q, ry_q;

  assign vec  = (stage_i.op == OP_TO_POLAR || stage_i.op == OP_DIST);
  assign x_in = stage_i.x;
  assign y_in = stage_i.y;

  always_comb begin
    g0_mx_d  = x_in[XY_W-1] ? XY_W'(-x_in) : XY_W'(x_in);
    g0_my_d  = y_in[XY_W-1] ? XY_W'(-y_in) : XY_W'(y_in);
    g0_ang_d = '0;
    if (vec && stage_i.zero) begin
      g0_mx_d = '0;
    end
    if (stage_i.op == OP_TO_POLAR && !stage_i.zero) begin
      g0_ang_d = stage_i.z[DW-1:0];
    end
  end

  assign sum_x = SUM_W'(g1_xlo_q) + {g1_xhi_q, {HALF_W{1'b0}}} + ROUND_BIT;
  assign sum_y = SUM_W'(g1_ylo_q) + {g1_yhi_q, {HALF_W{1'b0}}} + ROUND_BIT;

  always_comb begin
    clip_x = g2_negx_q ? (g2_rx_q > MAG_MAX_NEG) : (g2_rx_q > MAG_MAX_POS);
    clip_y = g2_negy_q ? (g2_ry_q > MAG_MAX_NEG) : (g2_ry_q > MAG_MAX_POS);
    if (clip_x) begin
      val_x = g2_negx_q ? SAT_NEG : SAT_POS;
    end else begin
      val_x = g2_negx_q ? -g2_rx_q[DW-1:0] : g2_rx_q[DW-1:0];
    end
    if (clip_y) begin
      val_y = g2_negy_q ? SAT_NEG : SAT_POS;
    end else begin
      val_y = g2_negy_q ? -g2_ry_q[DW-1:0] : g2_ry_q[DW-1:0];
    end
    rx_d      = val_x;
    ry_d      = g2_vec_q ? g2_ang_q : val_y;
    clipped_d = g2_vec_q ? clip_x : (clip_x | clip_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g0_valid_q <= 1'b0;
      g1_valid_q <= 1'b0;
      g2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      g0_valid_q <= valid_i;
      g1_valid_q <= g0_valid_q;
      g2_valid_q <= g1_valid_q;
      done_q     <= g2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g0_vec_q  <= vec;
    g0_negx_q <= x_in[XY_W-1] && !(vec && stage_i.zero);
    g0_negy_q <= y_in[XY_W-1];
    g0_mx_q   <= g0_mx_d;
    g0_my_q   <= g0_my_d;
    g0_ang_q  <= g0_ang_d;

    g1_vec_q  <= g0_vec_q;
    g1_negx_q <= g0_negx_q;
    g1_negy_q <= g0_negy_q;
    g1_xlo_q  <= PP_W'(g0_mx_q[HALF_W-1:0]) * PP_W'(K_GAIN);
    g1_xhi_q  <= PP_W'(g0_mx_q[XY_W-1:HALF_W]) * PP_W'(K_GAIN);
    g1_ylo_q  <= PP_W'(g0_my_q[HALF_W-1:0]) * PP_W'(K_GAIN);
    g1_yhi_q  <= PP_W'(g0_my_q[XY_W-1:HALF_W]) * PP_W'(K_GAIN);
    g1_ang_q  <= g0_ang_q;

    g2_vec_q  <= g1_vec_q;
    g2_negx_q <= g1_negx_q;
    g2_negy_q <= g1_negy_q;
    g2_rx_q   <= sum_x[SUM_W-1:K_W];
    g2_ry_q   <= sum_y[SUM_W-1:K_W];
    g2_ang_q  <= g1_ang_q;

    rx_q      <= rx_d;
    ry_q      <= ry_d;
    clipped_q <= clipped_d;
  end

  assign done_o    = done_q;
  assign rx_o      = rx_q;
  assign ry_o      = ry_q;
  assign clipped_o = clipped_q & done_q;

endmodule

`default_nettype wire

FILE: bench/planar_rotate_polar_unit_test.sv
`timescale 1ns / 1ps

package polar_check_pkg;
  import prp_pkg::*;

  localparam int unsigned CORDIC_STEPS = (STAGES_DEF > 32) ? 32 : STAGES_DEF;
  localparam logic [63:0] GAIN_Q30 = 64'd652032874;
  localparam logic [31:0] HALF_TURN_BAM = 32'h8000_0000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  localparam logic [31:0] ARCTAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    op_e         op;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        clipped;
  } xform_t;

  function automatic logic [31:0] clamp_q16(longint v, inout bit clip);
    if (v > Q_MAX) begin
      clip = 1'b1;
      return Q_MAX[31:0];
    end
    if (v < Q_MIN) begin
      clip = 1'b1;
      return Q_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // Round the magnitude half up, then restore the sign.
  function automatic longint drop_gain(longint v);
    logic [63:0] mag;
    logic [63:0] scaled;
    mag = (v < 0) ? -v : v;
    scaled = (mag * GAIN_Q30 + (64'd1 << 29)) >> 30;
    return (v < 0) ? -$signed(scaled) : $signed(scaled);
  endfunction

  function automatic void cordic_rotate(longint x, longint y, logic [31:0] ang,
                                        output longint ox, output longint oy);
    longint z;
    longint dx;
    longint dy;
    if (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) begin
      x = -x;
      y = -y;
      ang = ang + HALF_TURN_BAM;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ARCTAN_BAM[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ARCTAN_BAM[i]);
      end
    end
    ox = drop_gain(x);
    oy = drop_gain(y);
  endfunction

  function automatic void cordic_vector(longint x, longint y,
                                        output longint mag, output logic [31:0] ang);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = '0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(HALF_TURN_BAM);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ARCTAN_BAM[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ARCTAN_BAM[i]);
      end
    end
    mag = drop_gain(x);
    ang = z[31:0];
  endfunction

  function automatic xform_t cordic_transform(op_e op, int ax, int ay, int bx, int by,
                                              logic [31:0] turn);
    xform_t res;
    longint px;
    longint py;
    logic [31:0] ang;
    bit clip;
    clip = 1'b0;
    res.op = op;
    case (op)
      OP_ROTATE: begin
        cordic_rotate(longint'(ax), longint'(ay), turn, px, py);
        res.rx = clamp_q16(px, clip);
        res.ry = clamp_q16(py, clip);
      end
      OP_TO_CART: begin
        cordic_rotate(longint'(ax), 0, ay, px, py);
        res.rx = clamp_q16(px, clip);
        res.ry = clamp_q16(py, clip);
      end
      OP_TO_POLAR: begin
        cordic_vector(longint'(ax), longint'(ay), px, ang);
        res.rx = clamp_q16(px, clip);
        res.ry = ang;
      end
      default: begin
        cordic_vector(longint'(bx) - longint'(ax), longint'(by) - longint'(ay), px, ang);
        res.rx = clamp_q16(px, clip);
        res.ry = '0;
      end
    endcase
    res.clipped = clip;
    return res;
  endfunction

  class transform_scoreboard;
    xform_t      due_results[$];
    int unsigned mismatches = 0;
    int unsigned matched = 0;
    int unsigned op_seen[4] = '{0, 0, 0, 0};
    int unsigned clips_seen = 0;

    function void note_beat(op_e op, int ax, int ay, int bx, int by, logic [31:0] turn);
      due_results.push_back(cordic_transform(op, ax, ay, bx, by, turn));
      op_seen[op]++;
    endfunction

    function void check_beat(logic [31:0] rx, logic [31:0] ry, logic clipped);
      xform_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result rx=%h ry=%h clipped=%b", rx, ry, clipped);
        return;
      end
      want = due_results.pop_front();
      if (clipped) clips_seen++;
      if (rx !== want.rx || ry !== want.ry || clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s: expected rx=%h ry=%h clipped=%b, got rx=%h ry=%h clipped=%b",
                   want.op.name(), want.rx, want.ry, want.clipped, rx, ry, clipped);
      end else begin
        matched++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass
endpackage

module planar_rotate_polar_unit_test;
  import prp_pkg::*;
  import polar_check_pkg::*;

  localparam int LATENCY = STAGES_DEF + 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ONE = 32'h0001_0000;
  localparam int NUM_RANDOM = 550;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  op_i = '0;
  logic [31:0] ax_i = '0;
  logic [31:0] ay_i = '0;
  logic [31:0] bx_i = '0;
  logic [31:0] by_i = '0;
  logic [31:0] turn_i = '0;
  logic        done_o;
  logic [31:0] rx_o;
  logic [31:0] ry_o;
  logic        clipped_o;

  transform_scoreboard board;
  bit          idle_on = 1'b1;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  planar_rotate_polar_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .op_i      (op_i),
    .ax_i      (ax_i),
    .ay_i      (ay_i),
    .bx_i      (bx_i),
    .by_i      (by_i),
    .turn_i    (turn_i),
    .done_o    (done_o),
    .rx_o      (rx_o),
    .ry_o      (ry_o),
    .clipped_o (clipped_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        board.note_beat(op_e'(op_i), ax_i, ay_i, bx_i, by_i, turn_i);
      if (done_o)
        board.check_beat(rx_o, ry_o, clipped_o);
      if ((start_i && !busy_o) || done_o)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_item(op_e op, int ax, int ay, int bx, int by, logic [31:0] turn);
    bit hold_off;
    hold_off = 1'b1;
    while (hold_off) begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 99) < 27)
        start_i <= 1'b0;
      else
        hold_off = 1'b0;
    end
    op_i    <= op;
    ax_i    <= ax;
    ay_i    <= ay;
    bx_i    <= bx;
    by_i    <= by;
    turn_i  <= turn;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and hold until every pending beat has returned.
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  function automatic int rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 75) return int'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    if (sel < 90) begin
      if (sel[0]) return 32'h7FFF_FFFF - $urandom_range(0, 255);
      return 32'h8000_0000 + $urandom_range(0, 255);
    end
    return $urandom_range(0, 2) - 1;
  endfunction

  function automatic logic [31:0] rand_angle();
    logic [31:0] corner;
    if ($urandom_range(0, 99) < 70) return $urandom;
    corner = $urandom_range(0, 3) << 30;
    return corner + $urandom_range(0, 4) - 2;
  endfunction

  initial begin
    op_e op;
    int ax;
    int ay;
    int bx;
    int by;
    int unsigned sel;
    logic [31:0] turn;
    board = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_ROTATE, ONE, 0, $urandom, $urandom, 32'h0000_0000);
    send_item(OP_ROTATE, ONE, 0, $urandom, $urandom, 32'h4000_0000);
    send_item(OP_ROTATE, ONE, ONE, $urandom, $urandom, 32'h3FFF_FFFF);
    send_item(OP_ROTATE, ONE, -ONE, $urandom, $urandom, 32'h8000_0000);
    send_item(OP_ROTATE, -ONE, ONE, $urandom, $urandom, 32'hBFFF_FFFF);
    send_item(OP_ROTATE, 3 * ONE, 0, $urandom, $urandom, 32'hC000_0000);
    send_item(OP_ROTATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, $urandom, $urandom, 32'h2000_0000);
    send_item(OP_ROTATE, 32'h8000_0000, 32'h8000_0000, $urandom, $urandom, 32'hFFFF_FFFF);
    send_item(OP_TO_CART, 32'h7FFF_FFFF, 32'h0000_0000, $urandom, $urandom, $urandom);
    send_item(OP_TO_CART, 32'h8000_0000, 32'h6000_0000, $urandom, $urandom, $urandom);
    send_item(OP_TO_CART, ONE, 32'hFFFF_FFFF, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, 0, 0, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, -ONE, 0, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, -ONE, -1, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, 0, ONE, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, 32'h8000_0000, 32'h8000_0000, $urandom, $urandom, $urandom);
    send_item(OP_TO_POLAR, 32'h7FFF_FFFF, 0, $urandom, $urandom, $urandom);
    send_item(OP_DIST, 32'h1234_5678, -ONE, 32'h1234_5678, -ONE, $urandom);
    send_item(OP_DIST, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              $urandom);
    send_item(OP_DIST, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, $urandom);
    send_item(OP_DIST, 0, 0, 3 * ONE, 4 * ONE, $urandom);
    wait_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_on = !(n >= 200 && n < 320);
      if (n == 400) wait_drained();
      op = op_e'($urandom_range(0, 3));
      ax = rand_coord();
      ay = (op == OP_TO_CART) ? rand_angle() : rand_coord();
      bx = rand_coord();
      by = rand_coord();
      turn = rand_angle();
      sel = $urandom_range(0, 99);
      if (op == OP_TO_POLAR && sel < 5) begin
        ax = 0;
        ay = 0;
      end
      if (op == OP_DIST && sel < 5) begin
        bx = ax;
        by = ay;
      end
      send_item(op, ax, ay, bx, by, turn);
    end
    wait_drained();
    repeat (LATENCY + 4) @(negedge clk_i);

    $display("Sent %0d rotate, %0d polar-to-cartesian, %0d cartesian-to-polar, %0d distance",
             board.op_seen[OP_ROTATE], board.op_seen[OP_TO_CART],
             board.op_seen[OP_TO_POLAR], board.op_seen[OP_DIST]);
    $display("%0d results matched, %0d saturated, %0d mismatched",
             board.matched, board.clips_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
